FILE: rtl/wld_pkg.sv
// Shared types, codes and fixed widths of the weighted LD r-squared engine.
// Depends on nothing; all files but wld_ram import it.
`default_nettype none

package wld_pkg;

	localparam int FREQ_W = 16;
	localparam int ACC_W  = 32;
	localparam int TOT_W  = 9;
	localparam int RAH_W  = 2 * TOT_W;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int XW     = 42;
	localparam int WW     = 85;
	localparam int Q_W    = 16;

	localparam logic [TOT_W-1:0] TOT_MAX = '1;

	localparam logic [1:0] KIND_LOAD      = 2'd0;
	localparam logic [1:0] KIND_HOST      = 2'd1;
	localparam logic [1:0] KIND_SYM       = 2'd2;
	localparam logic [1:0] KIND_NONE      = 2'd3;
	localparam logic [1:0] ALLELE_REF     = 2'd0;
	localparam logic [1:0] ALLELE_ALT     = 2'd1;
	localparam logic [1:0] ALLELE_MISSING = 2'd2;
	localparam logic [1:0] ALLELE_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] big_a;
		logic [ACC_W-1:0] ab;
		logic [TOT_W-1:0] ref_tot;
		logic [TOT_W-1:0] alt_tot;
	} r2_req_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] r_squared;
		logic           undefined;
	} r2_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/wld_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module wld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/wld_mul.sv
// Shared 32 x 32 multiplier with a registered product.
// Depends on wld_pkg for the operand width.
`default_nettype none

module wld_mul import wld_pkg::*; (
	input  wire logic              clk,
	input  wire logic [MUL_W-1:0]  a,
	input  wire logic [MUL_W-1:0]  b,
	output logic      [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

FILE: rtl/wld_r2_unit.sv
// Sequencer that forms r-squared from the weighted sums and host totals.
// Depends on wld_pkg and on wld_mul, which it uses for every wide product.
`default_nettype none

module wld_r2_unit import wld_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire r2_req_t req,
	output r2_rsp_t      rsp
);

	localparam int LIMB = 32;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_M_X, ST_M_Y, ST_M_P, ST_M_RA, ST_M_D0, ST_M_D1,
		ST_M_D2, ST_M_N0, ST_M_N1, ST_M_N2, ST_CMP, ST_DIV, ST_DONE
	} state_t;

	state_t            state_q;
	logic [ACC_W-1:0]  a_q;
	logic [ACC_W-1:0]  ba_q;
	logic [ACC_W-1:0]  ab_q;
	logic [TOT_W-1:0]  r_q;
	logic [TOT_W-1:0]  ah_q;
	logic [XW-1:0]     x_q;
	logic [XW-1:0]     y_q;
	logic [XW-1:0]     d_q;
	logic [PROD_W-1:0] pp_q;
	logic [RAH_W-1:0]  rah_q;
	logic [WW-1:0]     num_q;
	logic [WW-1:0]     den_q;
	logic [Q_W-1:0]    q_q;
	logic [3:0]        bit_q;
	logic              undef_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [TOT_W:0]    h_sum;
	logic [WW-1:0]     num_sh;

	wld_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign h_sum  = {1'b0, r_q} + {1'b0, ah_q};
	assign num_sh = num_q << 1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M_X: begin
				mul_a = ab_q;
				mul_b = MUL_W'(h_sum);
			end
			ST_M_Y: begin
				mul_a = ba_q;
				mul_b = MUL_W'(ah_q);
			end
			ST_M_P: begin
				mul_a = a_q;
				mul_b = ba_q;
			end
			ST_M_RA: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(ah_q);
			end
			ST_M_D0: begin
				mul_a = d_q[LIMB-1:0];
				mul_b = d_q[LIMB-1:0];
			end
			ST_M_D1: begin
				mul_a = d_q[LIMB-1:0];
				mul_b = MUL_W'(d_q[XW-1:LIMB]);
			end
			ST_M_D2: begin
				mul_a = MUL_W'(d_q[XW-1:LIMB]);
				mul_b = MUL_W'(d_q[XW-1:LIMB]);
			end
			ST_M_N0: begin
				mul_a = pp_q[LIMB-1:0];
				mul_b = MUL_W'(rah_q);
			end
			ST_M_N1: begin
				mul_a = pp_q[PROD_W-1:LIMB];
				mul_b = MUL_W'(rah_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			undef_q <= 1'b0;
			q_q     <= '0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q     <= req.a;
						ba_q    <= req.big_a;
						ab_q    <= req.ab;
						r_q     <= req.ref_tot;
						ah_q    <= req.alt_tot;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (a_q == '0 || ba_q == '0 || r_q == '0 || ah_q == '0) begin
						undef_q <= 1'b1;
						q_q     <= '0;
						state_q <= ST_DONE;
					end else begin
						undef_q <= 1'b0;
						state_q <= ST_M_X;
					end
				end
				ST_M_X: state_q <= ST_M_Y;
				ST_M_Y: begin
					x_q     <= prod[XW-1:0];
					state_q <= ST_M_P;
				end
				ST_M_P: begin
					y_q     <= prod[XW-1:0];
					state_q <= ST_M_RA;
				end
				ST_M_RA: begin
					pp_q    <= prod;
					d_q     <= (x_q >= y_q) ? (x_q - y_q) : (y_q - x_q);
					state_q <= ST_M_D0;
				end
				ST_M_D0: begin
					rah_q   <= prod[RAH_W-1:0];
					state_q <= ST_M_D1;
				end
				ST_M_D1: begin
					num_q   <= WW'(prod);
					state_q <= ST_M_D2;
				end
				ST_M_D2: begin
					num_q   <= num_q + (WW'(prod) << (LIMB + 1));
					state_q <= ST_M_N0;
				end
				ST_M_N0: begin
					num_q   <= num_q + (WW'(prod) << (2 * LIMB));
					state_q <= ST_M_N1;
				end
				ST_M_N1: begin
					den_q   <= WW'(prod);
					state_q <= ST_M_N2;
				end
				ST_M_N2: begin
					den_q   <= den_q + (WW'(prod) << LIMB);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (num_q >= den_q) begin
						q_q     <= '1;
						state_q <= ST_DONE;
					end else begin
						q_q     <= '0;
						bit_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (num_sh >= den_q) begin
						num_q <= num_sh - den_q;
						q_q   <= {q_q[Q_W-2:0], 1'b1};
					end else begin
						num_q <= num_sh;
						q_q   <= {q_q[Q_W-2:0], 1'b0};
					end
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'(Q_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.done      = (state_q == ST_DONE);
	assign rsp.r_squared = q_q;
	assign rsp.undefined = undef_q;

endmodule

`default_nettype wire

FILE: rtl/weighted_ld_r2_engine.sv
// Top level of the weighted LD r-squared engine.
// Depends on wld_pkg, wld_ram, wld_mul and wld_r2_unit.
//
// A transaction is taken at a rising edge with start high and busy low.
// Kind 0 writes one entry of the STRAINS x HOSTS frequency table and never
// raises busy. Kind 1 adds one host allele and holds busy while the per-host
// counts are read and written back. Kind 2 adds one symbiont strain: the
// strain's row of the table is walked one host per cycle with busy high. A
// kind 2 transaction with last set then runs the r-squared sequencer (ten
// multiply steps on the shared multiplier, a compare and sixteen divide steps;
// the divide steps are skipped when the compare saturates the result, and the
// multiply and divide steps when a denominator factor is zero) and shows the
// result on r_squared and undefined with done high for exactly one cycle. The
// receiver cannot stall; a new transaction may be started in the cycle that
// done is high. After reset the frequency table is swept to zero with busy high;
// the state, valid flags, totals, sums and result registers clear at once.
`default_nettype none

module weighted_ld_r2_engine import wld_pkg::*; #(
	parameter int STRAINS      = 64,
	parameter int HOSTS        = 64,
	parameter int PLOIDY_LIMIT = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        kind,
	input  wire logic [5:0]        strain_index,
	input  wire logic [5:0]        host_index,
	input  wire logic [1:0]        allele_slot,
	input  wire logic [1:0]        allele_code,
	input  wire logic [FREQ_W-1:0] frequency,
	input  wire logic              last,
	output logic                   done,
	output logic      [Q_W-1:0]    r_squared,
	output logic                   undefined
);

	localparam int DEPTH = STRAINS * HOSTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HW    = (HOSTS > 1) ? $clog2(HOSTS) : 1;
	localparam int MW    = $clog2(HOSTS + 1);
	localparam int CW    = $clog2(PLOIDY_LIMIT + 1);
	localparam int WP_W  = FREQ_W + CW;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_HOST, ST_WALK, ST_R2_GO, ST_R2_WAIT
	} state_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
			input logic [ACC_W-1:0] v);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [HW-1:0]    hi_q;
	logic [1:0]       host_code_q;
	logic             sym_alt_q;
	logic             last_q;
	logic [AW-1:0]    base_q;
	logic [MW-1:0]    m_q;
	logic             rd_v_s1;
	logic [HW-1:0]    m_s1;
	logic [HOSTS-1:0] valid_q;
	logic [TOT_W-1:0] ref_tot_q;
	logic [TOT_W-1:0] alt_tot_q;
	logic             var_done_q;
	logic [ACC_W-1:0] ref_acc_q;
	logic [ACC_W-1:0] alt_acc_q;
	logic [ACC_W-1:0] joint_acc_q;
	logic             done_q;
	logic [Q_W-1:0]   r_sq_q;
	logic             undef_q;

	logic              s_ok;
	logic              h_ok;
	logic              slot_ok;
	logic [AW-1:0]     load_addr;
	logic [AW-1:0]     base_d;
	logic              f_we;
	logic [AW-1:0]     f_waddr;
	logic [FREQ_W-1:0] f_wdata;
	logic [AW-1:0]     f_raddr;
	logic [FREQ_W-1:0] f_rdata;
	logic              c_we;
	logic [HW-1:0]     c_raddr;
	logic [2*CW-1:0]   c_wdata;
	logic [2*CW-1:0]   c_rdata;
	logic [CW-1:0]     cur_slot;
	logic [CW-1:0]     cur_alt;
	logic [CW-1:0]     alt_inc;
	logic [CW-1:0]     w_slot;
	logic [CW-1:0]     w_alt;
	logic [WP_W-1:0]   w_slot_prod;
	logic [WP_W-1:0]   w_alt_prod;
	logic              r2_start;
	r2_req_t           r2_req;
	r2_rsp_t           r2_rsp;

	assign busy      = (state_q != ST_IDLE);
	assign s_ok      = int'(strain_index) < STRAINS;
	assign h_ok      = int'(host_index) < HOSTS;
	assign slot_ok   = int'(allele_slot) < PLOIDY_LIMIT;
	assign load_addr = AW'(int'(strain_index) * HOSTS + int'(host_index));
	assign base_d    = AW'(int'(strain_index) * HOSTS);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			f_we    = 1'b1;
			f_waddr = clr_q;
			f_wdata = '0;
		end else begin
			f_we    = start && (state_q == ST_IDLE) && (kind == KIND_LOAD) && s_ok && h_ok;
			f_waddr = load_addr;
			f_wdata = frequency;
		end
	end

	assign f_raddr = base_q + AW'(m_q[HW-1:0]);
	assign c_raddr = (state_q == ST_WALK) ? m_q[HW-1:0] : HW'(host_index);

	assign cur_slot = valid_q[hi_q] ? c_rdata[2*CW-1:CW] : '0;
	assign cur_alt  = valid_q[hi_q] ? c_rdata[CW-1:0] : '0;
	assign alt_inc  = (host_code_q == ALLELE_ALT) ? CW'(1) : '0;
	assign c_we     = (state_q == ST_HOST) && (cur_slot < CW'(PLOIDY_LIMIT));
	assign c_wdata  = {cur_slot + CW'(1), cur_alt + alt_inc};

	assign w_slot      = valid_q[m_s1] ? c_rdata[2*CW-1:CW] : '0;
	assign w_alt       = valid_q[m_s1] ? c_rdata[CW-1:0] : '0;
	assign w_slot_prod = f_rdata * w_slot;
	assign w_alt_prod  = f_rdata * w_alt;

	wld_ram #(
		.WIDTH (FREQ_W),
		.DEPTH (DEPTH)
	) u_freq_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	wld_ram #(
		.WIDTH (2 * CW),
		.DEPTH (HOSTS)
	) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (hi_q),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	assign r2_start       = (state_q == ST_R2_GO);
	assign r2_req.a       = ref_acc_q;
	assign r2_req.big_a   = alt_acc_q;
	assign r2_req.ab      = joint_acc_q;
	assign r2_req.ref_tot = ref_tot_q;
	assign r2_req.alt_tot = alt_tot_q;

	wld_r2_unit u_r2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (r2_start),
		.req    (r2_req),
		.rsp    (r2_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			m_q         <= '0;
			rd_v_s1     <= 1'b0;
			valid_q     <= '0;
			ref_tot_q   <= '0;
			alt_tot_q   <= '0;
			var_done_q  <= 1'b1;
			ref_acc_q   <= '0;
			alt_acc_q   <= '0;
			joint_acc_q <= '0;
			done_q      <= 1'b0;
			r_sq_q      <= '0;
			undef_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (kind)
							KIND_HOST: begin
								if (var_done_q) begin
									valid_q     <= '0;
									ref_tot_q   <= '0;
									alt_tot_q   <= '0;
									ref_acc_q   <= '0;
									alt_acc_q   <= '0;
									joint_acc_q <= '0;
								end
								var_done_q  <= last;
								hi_q        <= HW'(host_index);
								host_code_q <= allele_code;
								if (h_ok && slot_ok) begin
									state_q <= ST_HOST;
								end
							end
							KIND_SYM: begin
								last_q    <= last;
								sym_alt_q <= (allele_code == ALLELE_ALT);
								base_q    <= base_d;
								m_q       <= '0;
								if (s_ok && (allele_code == ALLELE_REF ||
										allele_code == ALLELE_ALT)) begin
									state_q <= ST_WALK;
								end else if (last) begin
									state_q <= ST_R2_GO;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_HOST: begin
					if (c_we) begin
						valid_q[hi_q] <= 1'b1;
						if (host_code_q == ALLELE_REF && ref_tot_q != TOT_MAX) begin
							ref_tot_q <= ref_tot_q + TOT_W'(1);
						end
						if (host_code_q == ALLELE_ALT && alt_tot_q != TOT_MAX) begin
							alt_tot_q <= alt_tot_q + TOT_W'(1);
						end
					end
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					rd_v_s1 <= (m_q != MW'(HOSTS));
					m_s1    <= m_q[HW-1:0];
					if (m_q != MW'(HOSTS)) begin
						m_q <= m_q + MW'(1);
					end
					if (rd_v_s1) begin
						if (sym_alt_q) begin
							alt_acc_q   <= sat_add(alt_acc_q, ACC_W'(w_slot_prod));
							joint_acc_q <= sat_add(joint_acc_q, ACC_W'(w_alt_prod));
						end else begin
							ref_acc_q <= sat_add(ref_acc_q, ACC_W'(w_slot_prod));
						end
					end
					if (m_q == MW'(HOSTS) && !rd_v_s1) begin
						state_q <= last_q ? ST_R2_GO : ST_IDLE;
					end
				end
				ST_R2_GO: state_q <= ST_R2_WAIT;
				ST_R2_WAIT: begin
					if (r2_rsp.done) begin
						done_q      <= 1'b1;
						r_sq_q      <= r2_rsp.r_squared;
						undef_q     <= r2_rsp.undefined;
						ref_acc_q   <= '0;
						alt_acc_q   <= '0;
						joint_acc_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign r_squared = r_sq_q;
	assign undefined = undef_q;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for weighted_ld_r2_engine: directed and random transactions
// are checked against a built-in predictor of the weighted LD r-squared results.
// Depends on wld_pkg and the engine RTL only.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wld_pkg::*;

	localparam int HOSTS          = 64;
	localparam int STRAINS        = 64;
	localparam int PLOIDY_LIMIT   = 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int PHASE_ITEMS    = 180;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [1:0]        kind;
		logic [5:0]        strain;
		logic [5:0]        host;
		logic [1:0]        slot;
		logic [1:0]        code;
		logic [FREQ_W-1:0] freq;
		logic              last;
	} txn_t;

	typedef struct packed {
		logic [Q_W-1:0] r_sq;
		logic           undef;
	} r2_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        kind = '0;
	logic [5:0]        strain_index = '0;
	logic [5:0]        host_index = '0;
	logic [1:0]        allele_slot = '0;
	logic [1:0]        allele_code = '0;
	logic [FREQ_W-1:0] frequency = '0;
	logic              last = 1'b0;
	wire logic         busy;
	wire logic         done;
	wire logic [Q_W-1:0] r_squared;
	wire logic         undefined;

	txn_t on_bus = '0;
	txn_t pending_txns[$];
	r2_t  r2_expected[$];
	int   idle_pct = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	logic [FREQ_W-1:0] freq_tab [STRAINS*HOSTS];
	logic [2:0]        slot_cnt [HOSTS];
	logic [2:0]        alt_cnt  [HOSTS];
	logic [TOT_W-1:0]  ref_total = '0;
	logic [TOT_W-1:0]  alt_total = '0;
	logic              variant_closed = 1'b1;
	logic [ACC_W-1:0]  ref_wsum = '0;
	logic [ACC_W-1:0]  alt_wsum = '0;
	logic [ACC_W-1:0]  joint_wsum = '0;

	weighted_ld_r2_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.strain_index(strain_index),
		.host_index(host_index),
		.allele_slot(allele_slot),
		.allele_code(allele_code),
		.frequency(frequency),
		.last(last),
		.done(done),
		.r_squared(r_squared),
		.undefined(undefined)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [ACC_W-1:0] sat_sum(logic [ACC_W-1:0] acc, logic [ACC_W-1:0] w);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + {1'b0, w};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	function automatic r2_t r2_of(logic [ACC_W-1:0] a, logic [ACC_W-1:0] big_a,
			logic [ACC_W-1:0] ab, logic [TOT_W-1:0] r, logic [TOT_W-1:0] ah);
		logic [63:0]  h, x, y, d, p;
		logic [127:0] num, den;
		r2_t          e;
		e = '0;
		if (a == 0 || big_a == 0 || r == 0 || ah == 0) begin
			e.undef = 1'b1;
			return e;
		end
		h = 64'(r) + 64'(ah);
		x = 64'(ab) * h;
		y = 64'(big_a) * 64'(ah);
		d = (x >= y) ? x - y : y - x;
		num = 128'(d) * 128'(d);
		p = 64'(a) * 64'(big_a);
		den = 128'(p) * 128'(64'(r) * 64'(ah));
		if (num >= den)
			e.r_sq = '1;
		else
			e.r_sq = Q_W'((num << Q_W) / den);
		return e;
	endfunction

	function automatic void clear_sums();
		ref_wsum = '0;
		alt_wsum = '0;
		joint_wsum = '0;
	endfunction

	function automatic void ld_model_step(txn_t t);
		logic [ACC_W-1:0] f;
		if (t.kind == KIND_LOAD) begin
			freq_tab[t.strain * HOSTS + t.host] = t.freq;
		end else if (t.kind == KIND_HOST) begin
			if (variant_closed) begin
				foreach (slot_cnt[m]) begin
					slot_cnt[m] = '0;
					alt_cnt[m] = '0;
				end
				ref_total = '0;
				alt_total = '0;
				clear_sums();
				variant_closed = 1'b0;
			end
			if (slot_cnt[t.host] < PLOIDY_LIMIT) begin
				slot_cnt[t.host]++;
				if (t.code == ALLELE_REF && ref_total != TOT_MAX)
					ref_total++;
				if (t.code == ALLELE_ALT) begin
					alt_cnt[t.host]++;
					if (alt_total != TOT_MAX)
						alt_total++;
				end
			end
			if (t.last)
				variant_closed = 1'b1;
		end else if (t.kind == KIND_SYM) begin
			if (t.code == ALLELE_REF || t.code == ALLELE_ALT) begin
				for (int m = 0; m < HOSTS; m++) begin
					f = ACC_W'(freq_tab[t.strain * HOSTS + m]);
					if (t.code == ALLELE_REF) begin
						ref_wsum = sat_sum(ref_wsum, f * slot_cnt[m]);
					end else begin
						alt_wsum = sat_sum(alt_wsum, f * slot_cnt[m]);
						joint_wsum = sat_sum(joint_wsum, f * alt_cnt[m]);
					end
				end
			end
			if (t.last) begin
				r2_expected.insert(r2_expected.size(),
					r2_of(ref_wsum, alt_wsum, joint_wsum, ref_total, alt_total));
				clear_sums();
			end
		end
	endfunction

	function automatic void push_txn(logic [1:0] k, logic [5:0] s, logic [5:0] h,
			logic [1:0] sl, logic [1:0] c, logic [FREQ_W-1:0] f, logic l);
		txn_t t;
		t = '{kind: k, strain: s, host: h, slot: sl, code: c, freq: f, last: l};
		pending_txns.insert(pending_txns.size(), t);
	endfunction

	function automatic logic [1:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return ALLELE_REF;
		if (r < 90)
			return ALLELE_ALT;
		return (r < 95) ? ALLELE_MISSING : ALLELE_UNKNOWN;
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return FREQ_W'($urandom);
	endfunction

	function automatic void queue_noise();
		push_txn(KIND_NONE, 6'($urandom), 6'($urandom), 2'($urandom), 2'($urandom),
			FREQ_W'($urandom), 1'($urandom));
	endfunction

	// One session: frequency loads, one host variant and one to four symbiont variants.
	function automatic void queue_session();
		logic [5:0] strain_set[6];
		logic [5:0] host_set[8];
		logic [5:0] s;
		int         ns, nh, nv, len, pl;
		ns = $urandom_range(1, 6);
		nh = $urandom_range(1, 8);
		foreach (strain_set[i])
			strain_set[i] = 6'($urandom);
		foreach (host_set[i])
			host_set[i] = 6'($urandom);
		for (int i = 0; i < ns; i++)
			for (int j = 0; j < nh; j++)
				if ($urandom_range(99) < 80)
					push_txn(KIND_LOAD, strain_set[i], host_set[j], 2'($urandom),
						2'($urandom), pick_freq(), 1'($urandom));
		if ($urandom_range(99) < 15)
			queue_noise();
		for (int j = 0; j < nh; j++) begin
			pl = ($urandom_range(99) < 10) ? PLOIDY_LIMIT + 1 : $urandom_range(1, PLOIDY_LIMIT);
			for (int k = 0; k < pl; k++)
				push_txn(KIND_HOST, 6'($urandom), host_set[j], 2'($urandom_range(0, 3)),
					pick_code(), FREQ_W'($urandom),
					(j == nh - 1) && (k == pl - 1) && ($urandom_range(99) < 95));
		end
		nv = $urandom_range(1, 4);
		for (int v = 0; v < nv; v++) begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 5)
					push_txn(KIND_HOST, 6'($urandom), 6'($urandom), 2'($urandom),
						pick_code(), FREQ_W'($urandom), 1'($urandom));
				if ($urandom_range(99) < 5)
					queue_noise();
				s = ($urandom_range(99) < 90) ? strain_set[$urandom_range(0, ns - 1)]
					: 6'($urandom);
				push_txn(KIND_SYM, s, 6'($urandom), 2'($urandom), pick_code(),
					FREQ_W'($urandom), k == len - 1);
			end
		end
	endfunction

	// Full table row and full host samples, so the alternate weighted sum saturates.
	function automatic void queue_saturation();
		logic [5:0] s;
		s = 6'($urandom);
		for (int h = 0; h < HOSTS; h++)
			push_txn(KIND_LOAD, s, 6'(h), 2'($urandom), 2'($urandom), '1, 1'($urandom));
		for (int h = 0; h < HOSTS; h++)
			for (int k = 0; k < PLOIDY_LIMIT; k++)
				push_txn(KIND_HOST, 6'($urandom), 6'(h), 2'(k),
					($urandom_range(1) != 0) ? ALLELE_ALT : ALLELE_REF, FREQ_W'($urandom),
					(h == HOSTS - 1) && (k == PLOIDY_LIMIT - 1));
		for (int k = 0; k < 270; k++)
			push_txn(KIND_SYM, s, 6'($urandom), 2'($urandom),
				(k < 5) ? ALLELE_REF : ALLELE_ALT, FREQ_W'($urandom), k == 269);
	endfunction

	task automatic wait_all_accepted();
		while (pending_txns.size() != 0 || start)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				ld_model_step(on_bus);
			if (!start || !busy) begin
				if (pending_txns.size() != 0 && $urandom_range(99) >= idle_pct) begin
					on_bus <= pending_txns[0];
					kind <= pending_txns[0].kind;
					strain_index <= pending_txns[0].strain;
					host_index <= pending_txns[0].host;
					allele_slot <= pending_txns[0].slot;
					allele_code <= pending_txns[0].code;
					frequency <= pending_txns[0].freq;
					last <= pending_txns[0].last;
					void'(pending_txns.pop_front());
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		r2_t e;
		if (arst_n) begin
			if (done) begin
				if (r2_expected.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("Unexpected result: r_squared=%h undefined=%b",
							r_squared, undefined);
					mismatches++;
				end else begin
					e = r2_expected.pop_front();
					if (r_squared !== e.r_sq || undefined !== e.undef) begin
						if (mismatches < MAX_REPORTS)
							$display("Mismatch: expected r_squared=%h undefined=%b, got %h %b",
								e.r_sq, e.undef, r_squared, undefined);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int phase_pct[4];
		int base;
		phase_pct = '{0, 45, 0, 37};
		foreach (freq_tab[i])
			freq_tab[i] = '0;
		foreach (slot_cnt[i]) begin
			slot_cnt[i] = '0;
			alt_cnt[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// An empty variant, a no-op kind, table corners, a host variant with missing,
		// unknown and overfull alleles, then symbiont variants around a new host variant.
		push_txn(KIND_SYM, 6'd0, 6'd0, 2'd0, ALLELE_REF, '0, 1'b1);
		push_txn(KIND_NONE, 6'd63, 6'd63, 2'd3, ALLELE_UNKNOWN, '1, 1'b1);
		push_txn(KIND_LOAD, 6'd0, 6'd0, 2'd0, ALLELE_REF, 16'h0001, 1'b0);
		push_txn(KIND_LOAD, 6'd63, 6'd63, 2'd3, ALLELE_UNKNOWN, 16'hFFFF, 1'b1);
		push_txn(KIND_LOAD, 6'd63, 6'd0, 2'd0, ALLELE_REF, 16'h8000, 1'b0);
		push_txn(KIND_LOAD, 6'd0, 6'd63, 2'd0, ALLELE_REF, 16'h7FFF, 1'b0);
		push_txn(KIND_LOAD, 6'd0, 6'd5, 2'd0, ALLELE_REF, 16'h0000, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd0, 2'd0, ALLELE_REF, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd0, 2'd1, ALLELE_ALT, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd63, 2'd3, ALLELE_ALT, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd63, 2'd0, ALLELE_MISSING, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd63, 2'd1, ALLELE_UNKNOWN, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd63, 2'd2, ALLELE_REF, '0, 1'b0);
		push_txn(KIND_HOST, 6'd0, 6'd63, 2'd2, ALLELE_ALT, '0, 1'b1);
		push_txn(KIND_SYM, 6'd0, 6'd0, 2'd0, ALLELE_REF, '0, 1'b0);
		push_txn(KIND_SYM, 6'd63, 6'd0, 2'd0, ALLELE_ALT, '0, 1'b0);
		push_txn(KIND_SYM, 6'd63, 6'd0, 2'd0, ALLELE_MISSING, '0, 1'b0);
		push_txn(KIND_SYM, 6'd0, 6'd0, 2'd0, ALLELE_UNKNOWN, '0, 1'b1);
		push_txn(KIND_SYM, 6'd63, 6'd0, 2'd0, ALLELE_ALT, '0, 1'b1);
		push_txn(KIND_HOST, 6'd0, 6'd5, 2'd0, ALLELE_ALT, '0, 1'b1);
		push_txn(KIND_SYM, 6'd0, 6'd0, 2'd0, ALLELE_REF, '0, 1'b0);
		push_txn(KIND_SYM, 6'd0, 6'd0, 2'd0, ALLELE_ALT, '0, 1'b1);
		wait_all_accepted();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_pct[ph];
			if (ph == 0)
				queue_saturation();
			base = pending_txns.size();
			while (pending_txns.size() - base < PHASE_ITEMS)
				queue_session();
			wait_all_accepted();
		end

		while (r2_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && r2_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
